// ===== hw/rtl/rwse_pkg.sv =====
// Package for the HLLC wave speed estimate pipeline.
// Holds widths, pipeline depths, saturation constants and helpers.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package rwse_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int RHO_W     = 31;
    localparam int NRM_W     = 18;
    localparam int GAMMA_W   = 19;
    localparam logic [GAMMA_W-1:0] GAMMA_RESET = GAMMA_W'(109227);

    // sound speed unit
    localparam int PROD_W   = GAMMA_W + DATA_W;          // gamma * |P|
    localparam int SQ_BITS  = 62;                         // radicand width
    localparam int Q_BITS   = SQ_BITS - FRAC_BITS;        // quotient bits kept
    localparam int SQ_N     = SQ_BITS / 2;                // root digits
    localparam int CS_W     = SQ_N;
    localparam int SQ_REM_W = CS_W + 4;
    localparam int M_W      = RHO_W + CS_W - FRAC_BITS;   // rho * cs
    localparam int SS_LAT   = Q_BITS + SQ_N + 3;

    // contact speed
    localparam int W_BITS = 30;
    localparam int S_W    = $clog2(M_W - W_BITS + 1);
    localparam int DEN_W  = W_BITS + 1;
    localparam int DP_W   = DATA_W + 1 + FRAC_BITS;
    localparam int MP_W   = W_BITS + DATA_W + 1;
    localparam int NUM_W  = 64;
    localparam int QC_W   = 32;

    localparam int DEPTH = SS_LAT + 6 + QC_W;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic                     ovf;
        logic signed [DATA_W-1:0] val;
    } sat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] vn1;
        logic signed [DATA_W-1:0] vn2;
        logic signed [DP_W-1:0]   dp;
        logic                     flag;
        logic                     zero;
    } ctx_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sl;
        logic signed [DATA_W-1:0] sr;
        logic                     flag;
        logic                     zero;
    } tail_t;

    typedef struct packed {
        logic neg;
        logic pos;
        logic dz;
        logic covf;
    } cflag_t;

    function automatic sat_t sat32(input logic signed [63:0] x);
        sat_t r;
        r.ovf = 1'b0;
        r.val = DATA_W'(x);
        if (x > 64'(S32_MAX))
        begin
            r.ovf = 1'b1;
            r.val = S32_MAX;
        end
        else if (x < 64'(S32_MIN))
        begin
            r.ovf = 1'b1;
            r.val = S32_MIN;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rwse_sound_speed.sv =====
// Pipelined sound speed of one side: q = gamma*|P|/rho, cs = isqrt(q << F),
// m = rho*cs >> F. Restoring divider then restoring square root, one digit
// per stage. Depends on rwse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwse_sound_speed
    import rwse_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [GAMMA_W-1:0]       gamma,
    input  logic [RHO_W-1:0]         rho,
    input  logic signed [DATA_W-1:0] pres,
    output logic [CS_W-1:0]          cs,
    output logic [M_W-1:0]           mass,
    output logic                     ovf
);

    logic [DATA_W-1:0] abs_p;
    logic [PROD_W-1:0] a_prod_reg;
    logic [RHO_W-1:0]  a_rho_reg;

    logic [PROD_W-1:0] b_prod_reg;
    logic [RHO_W-1:0]  b_rho_reg;
    logic [RHO_W-1:0]  b_rem_reg;
    logic              b_ovf_reg;

    logic [RHO_W-1:0]  dv_rem_reg  [Q_BITS];
    logic [Q_BITS-1:0] dv_quo_reg  [Q_BITS];
    logic [PROD_W-1:0] dv_prod_reg [Q_BITS];
    logic [RHO_W-1:0]  dv_rho_reg  [Q_BITS];
    logic              dv_ovf_reg  [Q_BITS];

    logic [SQ_REM_W-1:0] sq_rem_reg  [SQ_N];
    logic [CS_W-1:0]     sq_root_reg [SQ_N];
    logic [Q_BITS-1:0]   sq_q_reg    [SQ_N];
    logic [RHO_W-1:0]    sq_rho_reg  [SQ_N];
    logic                sq_ovf_reg  [SQ_N];

    logic [CS_W-1:0]        cs_fin;
    logic [RHO_W+CS_W-1:0]  m_full;
    logic [CS_W-1:0]        cs_reg;
    logic [M_W-1:0]         m_reg;
    logic                   ovf_reg;

    assign abs_p = pres[DATA_W-1] ? (~DATA_W'(pres) + DATA_W'(1)) : DATA_W'(pres);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= PROD_W'(gamma) * PROD_W'(abs_p);
            a_rho_reg  <= rho;
            // quotient must fit in Q_BITS, else cs saturates
            b_ovf_reg  <= (a_prod_reg >> Q_BITS) >= PROD_W'(a_rho_reg);
            b_rem_reg  <= RHO_W'(a_prod_reg >> Q_BITS);
            b_prod_reg <= a_prod_reg;
            b_rho_reg  <= a_rho_reg;
        end
    end

    for (genvar t = 0; t < Q_BITS; t++)
    begin : g_div
        logic [RHO_W-1:0]  rem_in;
        logic [RHO_W-1:0]  rho_in;
        logic [Q_BITS-1:0] quo_in;
        logic [PROD_W-1:0] prod_in;
        logic              ovf_in;
        logic [PROD_W-1:0] prod_sh;
        logic [RHO_W:0]    trial;

        if (t == 0)
        begin : g_first
            assign rem_in  = b_rem_reg;
            assign rho_in  = b_rho_reg;
            assign quo_in  = '0;
            assign prod_in = b_prod_reg;
            assign ovf_in  = b_ovf_reg;
        end
        else
        begin : g_next
            assign rem_in  = dv_rem_reg[t-1];
            assign rho_in  = dv_rho_reg[t-1];
            assign quo_in  = dv_quo_reg[t-1];
            assign prod_in = dv_prod_reg[t-1];
            assign ovf_in  = dv_ovf_reg[t-1];
        end

        assign prod_sh = prod_in >> (Q_BITS - 1 - t);
        assign trial   = {rem_in, prod_sh[0]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, rho_in})
                begin
                    dv_rem_reg[t] <= RHO_W'(trial - {1'b0, rho_in});
                    dv_quo_reg[t] <= {quo_in[Q_BITS-2:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[t] <= RHO_W'(trial);
                    dv_quo_reg[t] <= {quo_in[Q_BITS-2:0], 1'b0};
                end
                dv_prod_reg[t] <= prod_in;
                dv_rho_reg[t]  <= rho_in;
                dv_ovf_reg[t]  <= ovf_in;
            end
        end
    end

    for (genvar t = 0; t < SQ_N; t++)
    begin : g_sqrt
        logic [SQ_REM_W-1:0] rem_in;
        logic [CS_W-1:0]     root_in;
        logic [Q_BITS-1:0]   q_in;
        logic [RHO_W-1:0]    rho_in;
        logic                ovf_in;
        logic [SQ_BITS-1:0]  x_sh;
        logic [SQ_REM_W-1:0] rem4;
        logic [SQ_REM_W-1:0] trial;

        if (t == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign q_in    = dv_quo_reg[Q_BITS-1];
            assign rho_in  = dv_rho_reg[Q_BITS-1];
            assign ovf_in  = dv_ovf_reg[Q_BITS-1];
        end
        else
        begin : g_next
            assign rem_in  = sq_rem_reg[t-1];
            assign root_in = sq_root_reg[t-1];
            assign q_in    = sq_q_reg[t-1];
            assign rho_in  = sq_rho_reg[t-1];
            assign ovf_in  = sq_ovf_reg[t-1];
        end

        // radicand is q << F; take the next two bits from the top
        assign x_sh  = {q_in, {FRAC_BITS{1'b0}}} >> (SQ_BITS - 2 - 2 * t);
        assign rem4  = {rem_in[SQ_REM_W-3:0], x_sh[1:0]};
        assign trial = SQ_REM_W'({root_in, 2'b01});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem4 >= trial)
                begin
                    sq_rem_reg[t]  <= rem4 - trial;
                    sq_root_reg[t] <= {root_in[CS_W-2:0], 1'b1};
                end
                else
                begin
                    sq_rem_reg[t]  <= rem4;
                    sq_root_reg[t] <= {root_in[CS_W-2:0], 1'b0};
                end
                sq_q_reg[t]   <= q_in;
                sq_rho_reg[t] <= rho_in;
                sq_ovf_reg[t] <= ovf_in;
            end
        end
    end

    assign cs_fin = sq_ovf_reg[SQ_N-1] ? {CS_W{1'b1}} : sq_root_reg[SQ_N-1];
    assign m_full = (RHO_W+CS_W)'(sq_rho_reg[SQ_N-1]) * (RHO_W+CS_W)'(cs_fin);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cs_reg  <= cs_fin;
            m_reg   <= M_W'(m_full >> FRAC_BITS);
            ovf_reg <= sq_ovf_reg[SQ_N-1];
        end
    end

    assign cs   = cs_reg;
    assign mass = m_reg;
    assign ovf  = ovf_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/riemann_wave_speed_estimate.sv =====
// HLLC wave speed estimate, fully pipelined, one request per cycle.
// The two sound speed units feed the contact speed divider and then the output
// register.
// Throughput: one request per cycle; a stalled output freezes the whole pipe.
// Reset clears the valid pipeline and loads gamma = 5/3; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module riemann_wave_speed_estimate
    import rwse_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [GAMMA_W-1:0]       cfg_wr_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [RHO_W-1:0]         density_left,
    input  logic signed [DATA_W-1:0] pressure_left,
    input  logic signed [DATA_W-1:0] radial_vel_left,
    input  logic signed [DATA_W-1:0] polar_vel_left,
    input  logic [RHO_W-1:0]         density_right,
    input  logic signed [DATA_W-1:0] pressure_right,
    input  logic signed [DATA_W-1:0] radial_vel_right,
    input  logic signed [DATA_W-1:0] polar_vel_right,
    input  logic signed [NRM_W-1:0]  normal_radial,
    input  logic signed [NRM_W-1:0]  normal_polar,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] speed_left,
    output logic signed [DATA_W-1:0] speed_right,
    output logic signed [DATA_W-1:0] speed_contact,
    output logic                     degenerate
);

    localparam int VP_W = DATA_W + NRM_W;

    logic               adv;
    logic [DEPTH-1:0]   vld_reg;
    logic [GAMMA_W-1:0] gamma_reg;

    // stage 1
    logic signed [VP_W-1:0]   p_rl_reg, p_pl_reg, p_rr_reg, p_pr_reg;
    logic signed [DATA_W-1:0] p1_reg, p2_reg;
    logic                     zero_reg;

    // stage 2 .. SS_LAT
    ctx_t                   ctx_n;
    ctx_t                   ctx_reg [2:SS_LAT];
    logic signed [VP_W:0]   vs1, vs2;
    sat_t                   vsat1, vsat2;

    logic [CS_W-1:0] cs1, cs2;
    logic [M_W-1:0]  m1, m2;
    logic            sov1, sov2;

    // tail stages
    tail_t                    t1_n;
    tail_t                    t1_reg, t2_reg, t3_reg, t4_reg, t5_reg;
    logic signed [DATA_W+2:0] sr1, sr2, sl1, sl2, sr_max, sl_min;
    sat_t                     ssr, ssl;
    logic [M_W-1:0]           m_or;
    logic [S_W-1:0]           s_n;

    logic [M_W-1:0]           t1_m1_reg, t1_m2_reg;
    logic [S_W-1:0]           t1_s_reg;
    logic signed [DATA_W-1:0] t1_vn1_reg, t1_vn2_reg;
    logic signed [DP_W-1:0]   t1_dp_reg;

    logic [W_BITS-1:0]        t2_w1_reg, t2_w2_reg;
    logic signed [DATA_W-1:0] t2_vn1_reg, t2_vn2_reg;
    logic signed [DP_W-1:0]   t2_dp_reg;

    logic [W_BITS-1:0]        t3_w1_reg, t3_w2_reg;
    logic signed [MP_W-1:0]   t3_mp1_reg, t3_mp2_reg;
    logic signed [DP_W-1:0]   t3_dp_reg;

    logic signed [NUM_W-1:0]  t4_num_reg;
    logic [DEN_W-1:0]         t4_den_reg;

    logic [NUM_W-1:0]         absn;
    cflag_t                   cf_n;
    cflag_t                   t5_cf_reg;
    logic [DEN_W-1:0]         t5_rem_reg;
    logic [DEN_W-1:0]         t5_den_reg;
    logic [QC_W-1:0]          t5_lo_reg;

    logic [DEN_W-1:0] cd_rem_reg [QC_W];
    logic [DEN_W-1:0] cd_den_reg [QC_W];
    logic [QC_W-1:0]  cd_quo_reg [QC_W];
    logic [QC_W-1:0]  cd_lo_reg  [QC_W];
    cflag_t           cd_cf_reg  [QC_W];
    tail_t            cd_tl_reg  [QC_W];

    logic signed [DATA_W-1:0] sc_n, sl_o, sr_o;
    logic                     flag_o;
    logic signed [DATA_W-1:0] sl_reg, sr_reg, sc_reg;
    logic                     dg_reg;

    cflag_t    cf_l;
    tail_t     tl_l;
    logic [QC_W-1:0] quo_l;

    assign adv       = !vld_reg[DEPTH-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            gamma_reg <= GAMMA_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
            end
            if (cfg_wr_en)
            begin
                gamma_reg <= cfg_wr_data;
            end
        end
    end

    rwse_sound_speed u_ss_left
    (
        .clk   (clk),
        .en    (adv),
        .gamma (gamma_reg),
        .rho   (density_left),
        .pres  (pressure_left),
        .cs    (cs1),
        .mass  (m1),
        .ovf   (sov1)
    );

    rwse_sound_speed u_ss_right
    (
        .clk   (clk),
        .en    (adv),
        .gamma (gamma_reg),
        .rho   (density_right),
        .pres  (pressure_right),
        .cs    (cs2),
        .mass  (m2),
        .ovf   (sov2)
    );

    // normal velocity products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_rl_reg <= VP_W'(radial_vel_left) * VP_W'(normal_radial);
            p_pl_reg <= VP_W'(polar_vel_left) * VP_W'(normal_polar);
            p_rr_reg <= VP_W'(radial_vel_right) * VP_W'(normal_radial);
            p_pr_reg <= VP_W'(polar_vel_right) * VP_W'(normal_polar);
            p1_reg   <= pressure_left;
            p2_reg   <= pressure_right;
            zero_reg <= (density_left == '0) || (density_right == '0);
        end
    end

    always_comb
    begin
        vs1   = (VP_W+1)'(p_rl_reg) + (VP_W+1)'(p_pl_reg);
        vs2   = (VP_W+1)'(p_rr_reg) + (VP_W+1)'(p_pr_reg);
        vsat1 = sat32(64'(vs1 >>> FRAC_BITS));
        vsat2 = sat32(64'(vs2 >>> FRAC_BITS));
        ctx_n.vn1  = vsat1.val;
        ctx_n.vn2  = vsat2.val;
        ctx_n.dp   = (DP_W'(p1_reg) - DP_W'(p2_reg)) <<< FRAC_BITS;
        ctx_n.flag = vsat1.ovf | vsat2.ovf;
        ctx_n.zero = zero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[2] <= ctx_n;
            for (int k = 3; k <= SS_LAT; k++)
            begin
                ctx_reg[k] <= ctx_reg[k-1];
            end
        end
    end

    // signal speeds and the shift that brings both weights below 2^30
    always_comb
    begin
        sr1    = (DATA_W+3)'(ctx_reg[SS_LAT].vn1) + $signed((DATA_W+3)'(cs1));
        sr2    = (DATA_W+3)'(ctx_reg[SS_LAT].vn2) + $signed((DATA_W+3)'(cs2));
        sl1    = (DATA_W+3)'(ctx_reg[SS_LAT].vn1) - $signed((DATA_W+3)'(cs1));
        sl2    = (DATA_W+3)'(ctx_reg[SS_LAT].vn2) - $signed((DATA_W+3)'(cs2));
        sr_max = (sr1 < sr2) ? sr2 : sr1;
        sl_min = (sl1 > sl2) ? sl2 : sl1;
        ssr    = sat32(64'(sr_max));
        ssl    = sat32(64'(sl_min));
        t1_n.sl   = ssl.val;
        t1_n.sr   = ssr.val;
        t1_n.flag = ctx_reg[SS_LAT].flag | sov1 | sov2 | ssr.ovf | ssl.ovf;
        t1_n.zero = ctx_reg[SS_LAT].zero;
        m_or = m1 | m2;
        s_n  = '0;
        for (int b = W_BITS; b < M_W; b++)
        begin
            if (m_or[b])
            begin
                s_n = S_W'(b - W_BITS + 1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t1_reg     <= t1_n;
            t1_m1_reg  <= m1;
            t1_m2_reg  <= m2;
            t1_s_reg   <= s_n;
            t1_vn1_reg <= ctx_reg[SS_LAT].vn1;
            t1_vn2_reg <= ctx_reg[SS_LAT].vn2;
            t1_dp_reg  <= ctx_reg[SS_LAT].dp;

            t2_reg     <= t1_reg;
            t2_w1_reg  <= W_BITS'(t1_m1_reg >> t1_s_reg);
            t2_w2_reg  <= W_BITS'(t1_m2_reg >> t1_s_reg);
            t2_vn1_reg <= t1_vn1_reg;
            t2_vn2_reg <= t1_vn2_reg;
            t2_dp_reg  <= t1_dp_reg >>> t1_s_reg;

            t3_reg     <= t2_reg;
            t3_w1_reg  <= t2_w1_reg;
            t3_w2_reg  <= t2_w2_reg;
            t3_mp1_reg <= MP_W'($signed({1'b0, t2_w1_reg})) * MP_W'(t2_vn1_reg);
            t3_mp2_reg <= MP_W'($signed({1'b0, t2_w2_reg})) * MP_W'(t2_vn2_reg);
            t3_dp_reg  <= t2_dp_reg;

            t4_reg     <= t3_reg;
            t4_num_reg <= NUM_W'(t3_mp1_reg) + NUM_W'(t3_mp2_reg) + NUM_W'(t3_dp_reg);
            t4_den_reg <= DEN_W'(t3_w1_reg) + DEN_W'(t3_w2_reg);

            t5_reg     <= t4_reg;
            t5_cf_reg  <= cf_n;
            t5_rem_reg <= DEN_W'(absn >> QC_W);
            t5_den_reg <= t4_den_reg;
            t5_lo_reg  <= absn[QC_W-1:0];
        end
    end

    always_comb
    begin
        absn = t4_num_reg[NUM_W-1] ? NUM_W'(-t4_num_reg) : NUM_W'(t4_num_reg);
        cf_n.neg  = t4_num_reg[NUM_W-1];
        cf_n.pos  = !t4_num_reg[NUM_W-1] && (t4_num_reg != '0);
        cf_n.dz   = (t4_den_reg == '0);
        // quotient magnitude of 2^32 or more saturates
        cf_n.covf = (absn >> QC_W) >= NUM_W'(t4_den_reg);
    end

    for (genvar j = 0; j < QC_W; j++)
    begin : g_cdiv
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QC_W-1:0]  quo_in;
        logic [QC_W-1:0]  lo_in;
        cflag_t           cf_in;
        tail_t            tl_in;
        logic [DEN_W:0]   trial;

        if (j == 0)
        begin : g_first
            assign rem_in = t5_rem_reg;
            assign den_in = t5_den_reg;
            assign quo_in = '0;
            assign lo_in  = t5_lo_reg;
            assign cf_in  = t5_cf_reg;
            assign tl_in  = t5_reg;
        end
        else
        begin : g_next
            assign rem_in = cd_rem_reg[j-1];
            assign den_in = cd_den_reg[j-1];
            assign quo_in = cd_quo_reg[j-1];
            assign lo_in  = cd_lo_reg[j-1];
            assign cf_in  = cd_cf_reg[j-1];
            assign tl_in  = cd_tl_reg[j-1];
        end

        assign trial = {rem_in, lo_in[QC_W-1-j]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (trial >= {1'b0, den_in})
                begin
                    cd_rem_reg[j] <= DEN_W'(trial - {1'b0, den_in});
                    cd_quo_reg[j] <= {quo_in[QC_W-2:0], 1'b1};
                end
                else
                begin
                    cd_rem_reg[j] <= DEN_W'(trial);
                    cd_quo_reg[j] <= {quo_in[QC_W-2:0], 1'b0};
                end
                cd_den_reg[j] <= den_in;
                cd_lo_reg[j]  <= lo_in;
                cd_cf_reg[j]  <= cf_in;
                cd_tl_reg[j]  <= tl_in;
            end
        end
    end

    always_comb
    begin
        cf_l   = cd_cf_reg[QC_W-1];
        tl_l   = cd_tl_reg[QC_W-1];
        quo_l  = cd_quo_reg[QC_W-1];
        flag_o = tl_l.flag;
        sc_n   = DATA_W'(quo_l);
        if (cf_l.dz)
        begin
            flag_o = 1'b1;
            sc_n   = cf_l.pos ? S32_MAX : (cf_l.neg ? S32_MIN : '0);
        end
        else if (cf_l.covf)
        begin
            flag_o = 1'b1;
            sc_n   = cf_l.neg ? S32_MIN : S32_MAX;
        end
        else if (cf_l.neg)
        begin
            if (quo_l > QC_W'(32'h8000_0000))
            begin
                flag_o = 1'b1;
                sc_n   = S32_MIN;
            end
            else
            begin
                sc_n = DATA_W'(-quo_l);
            end
        end
        else if (quo_l > QC_W'(32'h7FFF_FFFF))
        begin
            flag_o = 1'b1;
            sc_n   = S32_MAX;
        end
        sl_o = tl_l.sl;
        sr_o = tl_l.sr;
        if (tl_l.zero)
        begin
            sl_o   = S32_MIN;
            sr_o   = S32_MAX;
            sc_n   = '0;
            flag_o = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sl_reg <= sl_o;
            sr_reg <= sr_o;
            sc_reg <= sc_n;
            dg_reg <= flag_o;
        end
    end

    assign speed_left    = sl_reg;
    assign speed_right   = sr_reg;
    assign speed_contact = sc_reg;
    assign degenerate    = dg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/rwse_checker.sv =====
// Port-level checks for the wave speed estimate block, bound to the top.
// Depends on rwse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rwse_checker
    import rwse_pkg::*;
(
    input wire logic                     clk,
    input wire logic                     rst_n,
    input wire logic                     cfg_wr_en,
    input wire logic [GAMMA_W-1:0]       cfg_wr_data,
    input wire logic                     in_valid,
    input wire logic                     in_ready,
    input wire logic [RHO_W-1:0]         density_left,
    input wire logic signed [DATA_W-1:0] pressure_left,
    input wire logic signed [DATA_W-1:0] radial_vel_left,
    input wire logic signed [DATA_W-1:0] polar_vel_left,
    input wire logic [RHO_W-1:0]         density_right,
    input wire logic signed [DATA_W-1:0] pressure_right,
    input wire logic signed [DATA_W-1:0] radial_vel_right,
    input wire logic signed [DATA_W-1:0] polar_vel_right,
    input wire logic signed [NRM_W-1:0]  normal_radial,
    input wire logic signed [NRM_W-1:0]  normal_polar,
    input wire logic                     out_valid,
    input wire logic                     out_ready,
    input wire logic signed [DATA_W-1:0] speed_left,
    input wire logic signed [DATA_W-1:0] speed_right,
    input wire logic signed [DATA_W-1:0] speed_contact,
    input wire logic                     degenerate
);

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(speed_left)
            && $stable(speed_right) && $stable(speed_contact) && $stable(degenerate))
        else $error("result changed while stalled");

    // the leftmost speed never exceeds the rightmost
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> speed_left <= speed_right)
        else $error("speed_left above speed_right");

    // input side stalls only behind a held result
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow the output stall");

    // a full stall lets no new request in
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken during stall");

endmodule

bind riemann_wave_speed_estimate rwse_checker u_rwse_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for riemann_wave_speed_estimate: directed and random interface states
// with bursty input, a stalling output side, and a scoreboard against a local predictor.
// Depends on rwse_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;
    import rwse_pkg::*;

    typedef struct {
        logic [RHO_W-1:0]         rho_l;
        logic signed [DATA_W-1:0] p_l;
        logic signed [DATA_W-1:0] vr_l;
        logic signed [DATA_W-1:0] vp_l;
        logic [RHO_W-1:0]         rho_r;
        logic signed [DATA_W-1:0] p_r;
        logic signed [DATA_W-1:0] vr_r;
        logic signed [DATA_W-1:0] vp_r;
        logic signed [NRM_W-1:0]  n_r;
        logic signed [NRM_W-1:0]  n_p;
    } iface_t;

    typedef struct {
        logic signed [DATA_W-1:0] sl;
        logic signed [DATA_W-1:0] sr;
        logic signed [DATA_W-1:0] sc;
        logic                     degen;
    } speeds_t;

    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [GAMMA_W-1:0] cfg_wr_data;
    logic in_valid;
    logic in_ready;
    logic [RHO_W-1:0] density_left;
    logic signed [DATA_W-1:0] pressure_left;
    logic signed [DATA_W-1:0] radial_vel_left;
    logic signed [DATA_W-1:0] polar_vel_left;
    logic [RHO_W-1:0] density_right;
    logic signed [DATA_W-1:0] pressure_right;
    logic signed [DATA_W-1:0] radial_vel_right;
    logic signed [DATA_W-1:0] polar_vel_right;
    logic signed [NRM_W-1:0] normal_radial;
    logic signed [NRM_W-1:0] normal_polar;
    logic out_valid;
    logic out_ready;
    logic signed [DATA_W-1:0] speed_left;
    logic signed [DATA_W-1:0] speed_right;
    logic signed [DATA_W-1:0] speed_contact;
    logic degenerate;

    iface_t  pending_states[$];
    speeds_t expected_speeds[$];
    longint unsigned gamma_cur;
    int fails;
    int results_seen;

    riemann_wave_speed_estimate DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .density_left(density_left), .pressure_left(pressure_left),
        .radial_vel_left(radial_vel_left), .polar_vel_left(polar_vel_left),
        .density_right(density_right), .pressure_right(pressure_right),
        .radial_vel_right(radial_vel_right), .polar_vel_right(polar_vel_right),
        .normal_radial(normal_radial), .normal_polar(normal_polar),
        .out_valid(out_valid), .out_ready(out_ready),
        .speed_left(speed_left), .speed_right(speed_right),
        .speed_contact(speed_contact), .degenerate(degenerate)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint clamp32(input longint x, inout bit flag);
        if (x > SMAX)
        begin
            flag = 1'b1;
            return SMAX;
        end
        if (x < SMIN)
        begin
            flag = 1'b1;
            return SMIN;
        end
        return x;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (x >= root + bitv)
            begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned sound_speed(input longint unsigned rho,
                                                    input longint p, inout bit flag);
        longint unsigned q;
        longint unsigned ap;
        ap = (p < 0) ? longint'(-p) : p;
        q = (gamma_cur * ap) / rho;
        if (q > (64'h3FFF_FFFF_FFFF_FFFF >> FRAC_BITS))
        begin
            flag = 1'b1;
            return 64'h7FFF_FFFF;
        end
        return int_sqrt(q << FRAC_BITS);
    endfunction

    function automatic speeds_t predict_speeds(input iface_t st);
        speeds_t r;
        bit flag;
        longint vn1, vn2, cs1, cs2, lo, hi, num, den, dp;
        longint unsigned m1, m2;
        int s;
        flag = 1'b0;
        s = 0;
        if (st.rho_l == 0 || st.rho_r == 0)
        begin
            r.sl = S32_MIN;
            r.sr = S32_MAX;
            r.sc = '0;
            r.degen = 1'b1;
            return r;
        end
        vn1 = clamp32((longint'(st.vr_l) * longint'(st.n_r)
                       + longint'(st.vp_l) * longint'(st.n_p)) >>> FRAC_BITS, flag);
        vn2 = clamp32((longint'(st.vr_r) * longint'(st.n_r)
                       + longint'(st.vp_r) * longint'(st.n_p)) >>> FRAC_BITS, flag);
        cs1 = sound_speed(64'(st.rho_l), st.p_l, flag);
        cs2 = sound_speed(64'(st.rho_r), st.p_r, flag);
        hi = (vn1 + cs1 > vn2 + cs2) ? vn1 + cs1 : vn2 + cs2;
        lo = (vn1 - cs1 < vn2 - cs2) ? vn1 - cs1 : vn2 - cs2;
        r.sr = DATA_W'(clamp32(hi, flag));
        r.sl = DATA_W'(clamp32(lo, flag));
        m1 = (longint'(st.rho_l) * cs1) >> FRAC_BITS;
        m2 = (longint'(st.rho_r) * cs2) >> FRAC_BITS;
        while ((m1 >> s) >= 64'h4000_0000 || (m2 >> s) >= 64'h4000_0000)
            s++;
        m1 = m1 >> s;
        m2 = m2 >> s;
        dp = (longint'(st.p_l) - longint'(st.p_r)) <<< FRAC_BITS;
        num = longint'(m1) * vn1 + longint'(m2) * vn2 + (dp >>> s);
        den = longint'(m1 + m2);
        if (den == 0)
        begin
            flag = 1'b1;
            r.sc = (num > 0) ? S32_MAX : ((num < 0) ? S32_MIN : '0);
        end
        else
            r.sc = DATA_W'(clamp32(num / den, flag));
        r.degen = flag;
        return r;
    endfunction

    function automatic logic signed [31:0] rand_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
        endcase
    endfunction

    function automatic logic [RHO_W-1:0] rand_rho();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return RHO_W'($urandom);
            3: return RHO_W'($urandom_range(1, 16));
            default: return RHO_W'($urandom_range(1, 32'h0040_0000));
        endcase
    endfunction

    function automatic logic signed [NRM_W-1:0] rand_normal();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, 1) ? 18'sd65536 : -18'sd65536;
        return NRM_W'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    function automatic iface_t rand_state();
        iface_t st;
        st.rho_l = rand_rho();
        st.p_l   = rand_val();
        st.vr_l  = rand_val();
        st.vp_l  = rand_val();
        st.rho_r = rand_rho();
        st.p_r   = rand_val();
        st.vr_r  = rand_val();
        st.vp_r  = rand_val();
        st.n_r   = rand_normal();
        st.n_p   = rand_normal();
        return st;
    endfunction

    // driver: bursts of requests separated by random gaps
    int burst_left;
    int gap_left;
    iface_t cur_state;
    always @(posedge clk or negedge rst_n)
    begin
        bit hold;
        iface_t st;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            hold = in_valid;
            if (in_valid && in_ready)
            begin
                expected_speeds.push_back(predict_speeds(cur_state));
                hold = 1'b0;
            end
            if (!hold)
            begin
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
                else if (pending_states.size() > 0)
                begin
                    st = pending_states.pop_front();
                    cur_state        <= st;
                    density_left     <= st.rho_l;
                    pressure_left    <= st.p_l;
                    radial_vel_left  <= st.vr_l;
                    polar_vel_left   <= st.vp_l;
                    density_right    <= st.rho_r;
                    pressure_right   <= st.p_r;
                    radial_vel_right <= st.vr_r;
                    polar_vel_right  <= st.vp_r;
                    normal_radial    <= st.n_r;
                    normal_polar     <= st.n_p;
                    hold = 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
            end
            in_valid <= hold;
        end
    end

    // receiver: rotating stall patterns, plus one long hold to back up the pipe
    int hold_cnt;
    bit long_hold_done;
    int pattern_cnt;
    int stall_pct;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready      <= 1'b0;
            hold_cnt       <= 0;
            long_hold_done <= 1'b0;
            pattern_cnt    <= 0;
            stall_pct      <= 0;
        end
        else if (hold_cnt > 0)
        begin
            hold_cnt  <= hold_cnt - 1;
            out_ready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= 300)
        begin
            long_hold_done <= 1'b1;
            hold_cnt       <= 600;
            out_ready      <= 1'b0;
        end
        else
        begin
            if (pattern_cnt == 0)
            begin
                pattern_cnt <= $urandom_range(50, 300);
                case ($urandom_range(0, 3))
                    0: stall_pct <= 0;
                    1: stall_pct <= 30;
                    2: stall_pct <= 60;
                    default: stall_pct <= 90;
                endcase
            end
            else
                pattern_cnt <= pattern_cnt - 1;
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        speeds_t exp_s;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_speeds.size() == 0)
            begin
                $error("result with no request outstanding");
                fails++;
            end
            else
            begin
                exp_s = expected_speeds.pop_front();
                if (speed_left !== exp_s.sl)
                begin
                    $error("speed_left expected %0d got %0d", exp_s.sl, speed_left);
                    fails++;
                end
                if (speed_right !== exp_s.sr)
                begin
                    $error("speed_right expected %0d got %0d", exp_s.sr, speed_right);
                    fails++;
                end
                if (speed_contact !== exp_s.sc)
                begin
                    $error("speed_contact expected %0d got %0d", exp_s.sc, speed_contact);
                    fails++;
                end
                if (degenerate !== exp_s.degen)
                begin
                    $error("degenerate expected %0b got %0b", exp_s.degen, degenerate);
                    fails++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_states.size() > 0 || in_valid || expected_speeds.size() > 0)
            @(posedge clk);
        repeat (130) @(posedge clk);
    endtask

    task automatic set_gamma(input logic [GAMMA_W-1:0] g);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= g;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        gamma_cur = 64'(g);
        @(posedge clk);
    endtask

    task automatic push_state(input logic [RHO_W-1:0] rl, input logic signed [31:0] pl,
                              input logic [RHO_W-1:0] rr, input logic signed [31:0] pr,
                              input logic signed [31:0] v,
                              input logic signed [NRM_W-1:0] nr,
                              input logic signed [NRM_W-1:0] np);
        iface_t st;
        st = '{rl, pl, v, -v, rr, pr, -v, v, nr, np};
        pending_states.push_back(st);
    endtask

    initial
    begin
        logic [GAMMA_W-1:0] gammas[5];
        iface_t st;
        gammas = '{19'd65537, 19'd327680, 19'd98304, GAMMA_RESET, 19'd0};
        fails = 0;
        results_seen = 0;
        gamma_cur = 64'(GAMMA_RESET);
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        density_left = '0;
        pressure_left = '0;
        radial_vel_left = '0;
        polar_vel_left = '0;
        density_right = '0;
        pressure_right = '0;
        radial_vel_right = '0;
        polar_vel_right = '0;
        normal_radial = '0;
        normal_polar = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed requests at the reset gamma
        push_state(31'd65536, 32'sd65536, 31'd65536, 32'sd65536, 32'sd0, 18'sd65536, 18'sd0);
        push_state('0, 32'sd65536, 31'd65536, 32'sd65536, 32'sd65536, 18'sd65536, 18'sd0);
        push_state(31'd65536, 32'sd65536, '0, -32'sd65536, 32'sd65536, 18'sd0, 18'sd65536);
        push_state('0, 32'sh7FFF_FFFF, '0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                   -18'sd65536, -18'sd65536);
        // sound speed overflow: tiny density, huge pressure
        push_state(31'd1, 32'sh7FFF_FFFF, 31'd1, 32'sh8000_0000, 32'sd0, 18'sd65536, 18'sd0);
        // zero pressure on both sides: zero contact denominator
        push_state(31'd65536, 32'sd0, 31'd65536, 32'sd0, 32'sd131072, 18'sd65536, 18'sd0);
        push_state(31'd65536, 32'sd0, 31'd65536, 32'sd0, -32'sd131072, 18'sd65536, 18'sd0);
        push_state(31'd65536, 32'sd0, 31'd65536, 32'sd0, 32'sd0, 18'sd0, 18'sd0);
        // extreme densities, pressures and velocities
        push_state(31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF, 32'sh8000_0000,
                   32'sh8000_0000, -18'sd65536, 18'sd65536);
        push_state(31'h7FFF_FFFF, 32'sh7FFF_FFFF, 31'd1, 32'sd1, 32'sh7FFF_FFFF,
                   18'sd65536, 18'sd65536);
        push_state(31'd1, -32'sd1, 31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh4000_0000,
                   18'sd46341, -18'sd46341);
        push_state(31'h7FFF_FFFF, 32'sh8000_0000, 31'h7FFF_FFFF, 32'sh7FFF_FFFF,
                   32'sd1000, 18'sd46341, 18'sd46341);
        for (int i = 0; i < 8; i++)
            pending_states.push_back(rand_state());
        drain();

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph < 4)
                set_gamma(gammas[ph]);
            else
                set_gamma(GAMMA_W'($urandom_range(65537, 327680)));
            for (int i = 0; i < 380; i++)
            begin
                st = rand_state();
                pending_states.push_back(st);
            end
            drain();
        end

        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/rwse_pkg.sv
hw/rtl/rwse_sound_speed.sv
hw/rtl/riemann_wave_speed_estimate.sv
hw/rtl/rwse_checker.sv
tb/sv/testbench.sv
